// ----- src/wide_restoring_divider_defines.svh -----
// assertion macros shared by the divider checker
`ifndef WIDE_RESTORING_DIVIDER_DEFINES_SVH
`define WIDE_RESTORING_DIVIDER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wrd_pkg.sv -----
// types and constants of the wide restoring divider
`timescale 1ns / 1ps

package wrd_pkg;

    localparam int DIVIDEND_W = 192;
    localparam int DIVISOR_W  = 96;
    localparam int COUNT_W    = $clog2(DIVIDEND_W);
    localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(DIVIDEND_W - 1);

    // result of one shift-and-subtract step
    typedef struct packed {
        logic                 take;
        logic [DIVISOR_W-1:0] rem;
    } t_step_res;

endpackage

// ----- src/wrd_step_unit.sv -----
// shared shift, compare and subtract unit: one quotient bit per use
`timescale 1ns / 1ps

module wrd_step_unit (
    input  logic [wrd_pkg::DIVISOR_W-1:0] i_rem,
    input  logic                          i_bit,
    input  logic [wrd_pkg::DIVISOR_W-1:0] i_divisor,
    output wrd_pkg::t_step_res            o_res
);

    logic                          carry;
    logic [wrd_pkg::DIVISOR_W-1:0] shifted;
    logic [wrd_pkg::DIVISOR_W+1:0] diff;

    // shift in the next dividend bit, keep the bit pushed out at the top
    assign carry   = i_rem[wrd_pkg::DIVISOR_W-1];
    assign shifted = {i_rem[wrd_pkg::DIVISOR_W-2:0], i_bit};

    // trial subtraction on the 97-bit partial remainder, no borrow means the divisor fits
    assign diff = {1'b0, carry, shifted} - {2'b00, i_divisor};

    always_comb begin
        o_res.take = ~diff[wrd_pkg::DIVISOR_W+1];
        o_res.rem  = o_res.take ? diff[wrd_pkg::DIVISOR_W-1:0] : shifted;
    end

endmodule

// ----- src/wide_restoring_divider.sv -----
// top level of the 192-by-96 bit unsigned restoring divider
`timescale 1ns / 1ps

// Unsigned 192-bit by 96-bit divider giving a 192-bit quotient and a
// 96-bit remainder. A request first has its operands loaded; a single
// shift-and-subtract unit then produces the quotient bits one at a time,
// most significant first; last, the result is moved into the output
// register as soon as that register is free. The input side stalls for
// the whole division; a finished result sits in its own register, so the
// next request may be taken while it waits. A zero divisor yields an
// all-ones quotient, dividend bits 95..0 as the remainder and sets
// o_divide_by_zero.
module wide_restoring_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_dividend_low,
    input  logic [63:0] i_dividend_mid,
    input  logic [63:0] i_dividend_high,
    input  logic [63:0] i_divisor_low,
    input  logic [31:0] i_divisor_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_quotient_low,
    output logic [63:0] o_quotient_mid,
    output logic [63:0] o_quotient_high,
    output logic [63:0] o_remainder_low,
    output logic [31:0] o_remainder_high,
    output logic        o_divide_by_zero
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    t_state                                r_state;
    logic [wrd_pkg::COUNT_W-1:0]           r_count;
    logic [wrd_pkg::DIVIDEND_W-1:0]        r_quo;
    logic [wrd_pkg::DIVISOR_W-1:0]         r_rem;
    logic [wrd_pkg::DIVISOR_W-1:0]         r_div;
    logic                                  r_dz;
    logic                                  r_out_valid;
    logic [wrd_pkg::DIVIDEND_W-1:0]        r_out_quo;
    logic [wrd_pkg::DIVISOR_W-1:0]         r_out_rem;
    logic                                  r_out_dz;
    wrd_pkg::t_step_res                    step;
    logic [wrd_pkg::DIVISOR_W-1:0]         n_div;

    assign n_div = {i_divisor_high, i_divisor_low};

    // one quotient bit per cycle while in S_RUN; dividend shifts out the top of r_quo
    wrd_step_unit u_step (
        .i_rem     (r_rem),
        .i_bit     (r_quo[wrd_pkg::DIVIDEND_W-1]),
        .i_divisor (r_div),
        .o_res     (step)
    );

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register empties once taken, unless refilled below
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_quo   <= {i_dividend_high, i_dividend_mid, i_dividend_low};
                        r_rem   <= '0;
                        r_div   <= n_div;
                        r_dz    <= (n_div == '0);
                        r_count <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_quo   <= {r_quo[wrd_pkg::DIVIDEND_W-2:0], step.take};
                    r_rem   <= step.rem;
                    r_count <= r_count + 1'b1;
                    if (r_count == wrd_pkg::LAST_STEP) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // wait for the output register to be free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_quo   <= r_quo;
                        r_out_rem   <= r_rem;
                        r_out_dz    <= r_dz;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_quotient_low   = r_out_quo[63:0];
    assign o_quotient_mid   = r_out_quo[127:64];
    assign o_quotient_high  = r_out_quo[191:128];
    assign o_remainder_low  = r_out_rem[63:0];
    assign o_remainder_high = r_out_rem[95:64];
    assign o_divide_by_zero = r_out_dz;

endmodule

// ----- src/wrd_checker.sv -----
// port-level assertions for the divider, bound to the top level
`timescale 1ns / 1ps
`include "wide_restoring_divider_defines.svh"

module wrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_quotient_low,
    input logic [63:0] o_quotient_mid,
    input logic [63:0] o_quotient_high,
    input logic [63:0] o_remainder_low,
    input logic [31:0] o_remainder_high,
    input logic        o_divide_by_zero
);

    // a stalled result stays offered
    `WRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // a stalled result keeps its low and high quotient, low remainder and divide-by-zero flag
    `WRD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_quotient_low) && $stable(o_quotient_high) && $stable(o_remainder_low) && $stable(o_divide_by_zero), "stalled result changed")

    // an accepted request makes the input side stall while dividing
    `WRD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled during division")

    // zero divisor always gives an all-ones quotient
    `WRD_ASSERT_SAME(a_dz_quotient, i_clk, i_rst_n, o_out_valid && o_divide_by_zero, (&o_quotient_low) && (&o_quotient_mid) && (&o_quotient_high), "zero divisor quotient not all ones")

endmodule

bind wide_restoring_divider wrd_checker u_wrd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_quotient_low   (o_quotient_low),
    .o_quotient_mid   (o_quotient_mid),
    .o_quotient_high  (o_quotient_high),
    .o_remainder_low  (o_remainder_low),
    .o_remainder_high (o_remainder_high),
    .o_divide_by_zero (o_divide_by_zero)
);
